[rtl/breakpoint_envelope_table_defines.svh]
// Assertion macros for the breakpoint envelope table.
// Depends on signals clk and rst_n in the module that uses them.
`ifndef BREAKPOINT_ENVELOPE_TABLE_DEFINES_SVH
`define BREAKPOINT_ENVELOPE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define BET_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`define BET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define BET_ASSERT_IMPL(label, ante, cons)
`define BET_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/bet_pkg.sv]
// Shared types and constants for the breakpoint envelope table.
// No dependencies.
package bet_pkg;
    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int FRAME_BITS = 48;
    localparam int VAL_W      = 18;
    localparam int PROD_W     = FRAME_BITS + VAL_W;
    localparam int STEP_W     = $clog2(PROD_W + 1);
    localparam int IN_W       = 72;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT  = 1'd1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [FRAME_BITS-1:0]   frame;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]        point_count;
        logic                    status;
        logic signed [VAL_W-1:0] value;
    } res_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0]   frame;
        logic signed [VAL_W-1:0] value;
    } point_t;
endpackage

[rtl/bet_front.sv]
// Front end: accepts input transactions, decodes the operation, queues them.
// Depends on bet_pkg.
module bet_front
    import bet_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    output logic            item_valid,
    input  logic            item_ready,
    output item_t           item,
    output logic [1:0]      level
);
    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    // tdata: func[1:0], frame_in[49:2], value_in[67:50]
    always_comb
    begin
        in_item.op    = op_t'(s_tdata[1:0]);
        in_item.frame = s_tdata[FRAME_BITS+1:2];
        in_item.value = s_tdata[FRAME_BITS+VAL_W+1:FRAME_BITS+2];
    end

    assign s_tready   = (level_reg != 2'd2);
    assign item_valid = (level_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 2'd1;
            end
        end
    end
endmodule

[rtl/bet_back.sv]
// Back end: point memory, sorted insert, query scan and interpolation.
// Depends on bet_pkg.
module bet_back
    import bet_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  item_t                   item,
    input  logic                    discrete_mode,
    input  logic signed [VAL_W-1:0] default_value,
    output logic                    res_valid,
    input  logic                    res_ready,
    output res_t                    res
);
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS_RD  = 9'b000000010,
        S_INS_CHK = 9'b000000100,
        S_QRY_RD  = 9'b000001000,
        S_QRY_CHK = 9'b000010000,
        S_MUL     = 9'b000100000,
        S_DIV     = 9'b001000000,
        S_FIN     = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [FRAME_BITS-1:0]   f_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic [FRAME_BITS-1:0]   prev_f_reg;
    logic signed [VAL_W-1:0] prev_v_reg;
    logic [VAL_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       mul_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic [FRAME_BITS-1:0]   den_reg;
    logic [FRAME_BITS-1:0]   rem_reg;
    logic [VAL_W-1:0]        q_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    status_reg;

    point_t                  mem [MAX_POINTS];
    point_t                  rdata_reg;
    logic                    mem_we;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ADDR_W-1:0]       mem_raddr;
    point_t                  mem_wdata;
    logic [CNT_W-1:0]        idx_dec;

    logic                    hit;
    logic signed [VAL_W:0]   dv;
    logic [VAL_W:0]          dv_abs;
    logic [FRAME_BITS:0]     rem_s;
    logic                    rem_ge;
    logic signed [VAL_W:0]   fin_sum;

    assign idx_dec    = idx_reg - 1'b1;
    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res        = '{point_count: cnt_reg, status: status_reg, value: val_reg};

    assign hit    = (f_reg <= rdata_reg.frame);
    assign dv     = {rdata_reg.value[VAL_W-1], rdata_reg.value}
                  - {prev_v_reg[VAL_W-1], prev_v_reg};
    assign dv_abs = dv[VAL_W] ? -dv : dv;
    assign rem_s  = {rem_reg, acc_reg[PROD_W-1]};
    assign rem_ge = (rem_s >= {1'b0, den_reg});
    assign fin_sum = neg_reg
                   ? ({prev_v_reg[VAL_W-1], prev_v_reg} - {1'b0, q_reg})
                   : ({prev_v_reg[VAL_W-1], prev_v_reg} + {1'b0, q_reg});

    // memory port control: insert shifts entries up by one from the top down
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = idx_reg[ADDR_W-1:0];
        mem_raddr = idx_reg[ADDR_W-1:0];
        mem_wdata = '{frame: f_reg, value: v_reg};
        unique case (state_reg)
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec[ADDR_W-1:0];
                end
            end
            S_INS_CHK:
            begin
                mem_we = 1'b1;
                if (rdata_reg.frame > f_reg)
                begin
                    mem_wdata = rdata_reg;
                end
            end
            S_QRY_RD:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                f_reg <= item.frame;
                v_reg <= item.value;
            end
            S_QRY_CHK:
            begin
                if (!hit)
                begin
                    prev_f_reg <= rdata_reg.frame;
                    prev_v_reg <= rdata_reg.value;
                end
                mag_reg <= dv_abs[VAL_W-1:0];
                neg_reg <= dv[VAL_W];
                den_reg <= rdata_reg.frame - prev_f_reg;
                mul_reg <= {{VAL_W{1'b0}}, f_reg - prev_f_reg};
                acc_reg <= '0;
                rem_reg <= '0;
                q_reg   <= '0;
            end
            S_MUL:
            begin
                if (mag_reg[0])
                begin
                    acc_reg <= acc_reg + mul_reg;
                end
                mul_reg <= mul_reg << 1;
                mag_reg <= mag_reg >> 1;
            end
            S_DIV:
            begin
                acc_reg <= acc_reg << 1;
                if (rem_ge)
                begin
                    rem_reg <= FRAME_BITS'(rem_s - {1'b0, den_reg});
                    q_reg   <= {q_reg[VAL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_s[FRAME_BITS-1:0];
                    q_reg   <= {q_reg[VAL_W-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            step_reg   <= '0;
            val_reg    <= '0;
            status_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        case (item.op)
                            OP_CLEAR:
                            begin
                                cnt_reg    <= '0;
                                val_reg    <= '0;
                                status_reg <= 1'b0;
                                state_reg  <= S_OUT;
                            end
                            OP_INSERT:
                            begin
                                val_reg <= '0;
                                if (cnt_reg >= CNT_W'(MAX_POINTS))
                                begin
                                    status_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    status_reg <= 1'b0;
                                    idx_reg    <= cnt_reg;
                                    state_reg  <= S_INS_RD;
                                end
                            end
                            OP_QUERY:
                            begin
                                status_reg <= 1'b0;
                                if (cnt_reg == '0)
                                begin
                                    val_reg   <= default_value;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    val_reg   <= '0;
                                    idx_reg   <= '0;
                                    state_reg <= S_QRY_RD;
                                end
                            end
                            default:
                            begin
                                val_reg    <= '0;
                                status_reg <= 1'b0;
                                state_reg  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_INS_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_INS_CHK;
                    end
                end
                S_INS_CHK:
                begin
                    if (rdata_reg.frame > f_reg)
                    begin
                        idx_reg   <= idx_dec;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_QRY_RD:
                begin
                    state_reg <= S_QRY_CHK;
                end
                S_QRY_CHK:
                begin
                    if (hit)
                    begin
                        if (idx_reg == '0 || (discrete_mode && f_reg == rdata_reg.frame))
                        begin
                            val_reg   <= rdata_reg.value;
                            state_reg <= S_OUT;
                        end
                        else if (discrete_mode || rdata_reg.frame == prev_f_reg)
                        begin
                            val_reg   <= prev_v_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            step_reg  <= STEP_W'(VAL_W);
                            state_reg <= S_MUL;
                        end
                    end
                    else if (idx_reg == cnt_reg - 1'b1)
                    begin
                        val_reg   <= rdata_reg.value;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_QRY_RD;
                    end
                end
                S_MUL:
                begin
                    if (step_reg == STEP_W'(1))
                    begin
                        step_reg  <= STEP_W'(PROD_W);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    val_reg   <= fin_sum[VAL_W-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[rtl/breakpoint_envelope_table.sv]
// Top level of the breakpoint envelope table: config registers, front, back, output register.
// Depends on bet_pkg, bet_front, bet_back and breakpoint_envelope_table_defines.svh.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one transaction per operation:
//   clear the table, insert a (frame, value) point in sorted order, or query a frame.
//   Output stream (m_tvalid/m_tready/m_tdata) returns exactly one result per input.
//   Config port (cfg_we/cfg_addr/cfg_wdata): index 0 discrete mode, index 1 default value;
//   write only while the block is idle.
//   Clear and no-op go straight to the result. Insert moves each point with a larger
//   frame up by one, reading and writing from the top down, then writes the new point.
//   A query reads points in order up to the first point at or past the frame or the
//   last point; linear interpolation then adds a shift-add multiply, a restoring
//   division and the final sum. The point memory, read one point at a time, and the
//   serial multiply/divide set how long each operation takes; one operation is in flight
//   in the back end at a time.
//   A two-entry queue lets the front take transactions while the back end works, and
//   the output register holds a result while the back end finishes the next one.
//   Reset clears the point count, the queue and the config registers; the point
//   memory itself is not cleared. If the receiver stalls, the result waits in the
//   output register and the back end stops once its next result is ready.
`include "breakpoint_envelope_table_defines.svh"
module breakpoint_envelope_table
    import bet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // func[1:0], frame_in[49:2], value_in[67:50]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // value_out[17:0], status[18], point_count[27:19]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [VAL_W-1:0]     cfg_wdata
);
    logic                    discrete_mode_reg;
    logic signed [VAL_W-1:0] default_value_reg;
    logic                    item_valid;
    logic                    item_ready;
    item_t                   item;
    logic [1:0]              level;
    logic                    res_valid;
    logic                    res_ready;
    res_t                    res;
    logic                    out_valid_reg;
    res_t                    out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discrete_mode_reg <= 1'b0;
            default_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DISCRETE: discrete_mode_reg <= cfg_wdata[0];
                CFG_DEFAULT:  default_value_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    bet_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .level      (level)
    );

    bet_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .discrete_mode (discrete_mode_reg),
        .default_value (default_value_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // output register: takes a new result whenever empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - CNT_W - 1 - VAL_W){1'b0}}, out_reg};

    `BET_ASSERT_IMPL(a_count_bound, res_valid, res.point_count <= CNT_W'(MAX_POINTS))
    `BET_ASSERT_IMPL(a_drop_zero, res_valid && res.status, res.value == '0)
    `BET_ASSERT_NEXT(a_queue_bound, level == 2'd2 && !item_ready, level == 2'd2)
endmodule

[sim/breakpoint_envelope_table_tb.sv]
// Testbench for breakpoint_envelope_table: directed and random clear/insert/query/no-op traffic
// checked against a behavioral model of the sorted breakpoint table. Depends on bet_pkg.
`timescale 1ns / 1ps
module breakpoint_envelope_table_tb;
    import bet_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int IDLE_LIMIT = 20000;   // watchdog limit; covers the slowest op plus receiver stall

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;    // func[1:0], frame_in[49:2], value_in[67:50]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;    // value_out[17:0], status[18], point_count[27:19]
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [VAL_W-1:0]     cfg_wdata;

    breakpoint_envelope_table uut (.*);

    // One transaction as it goes on the wire, and one expected result.
    typedef struct {
        op_t                     op;
        logic [FRAME_BITS-1:0]   frame;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    status;
        logic [CNT_W-1:0]        point_count;
    } env_result_t;

    cmd_t        pending_cmds[$];
    env_result_t expected_results[$];

    // Model of the envelope table
    logic [FRAME_BITS-1:0]   tbl_frame[MAX_POINTS];
    logic signed [VAL_W-1:0] tbl_value[MAX_POINTS];
    int                      tbl_count;
    logic                    mdl_discrete;
    logic signed [VAL_W-1:0] mdl_default;

    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_sender;
    int  quiet_cycles;
    bit  in_taken;      // input transaction accepted at the last rising edge

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Evaluate the envelope at frame f on the model table.
    function automatic logic signed [VAL_W-1:0] envelope_at(input logic [FRAME_BITS-1:0] f);
        logic [FRAME_BITS-1:0] pf;
        logic [FRAME_BITS-1:0] nf;
        longint                dv;
        logic [127:0]          num;
        logic [127:0]          q;
        if (tbl_count == 0)
            return mdl_default;
        if (f <= tbl_frame[0])
            return tbl_value[0];
        for (int i = 1; i < tbl_count; i++)
        begin
            pf = tbl_frame[i-1];
            nf = tbl_frame[i];
            if (f <= nf)
            begin
                if (mdl_discrete && f == nf)
                    return tbl_value[i];
                if (mdl_discrete || nf == pf)
                    return tbl_value[i-1];
                dv  = longint'(tbl_value[i]) - longint'(tbl_value[i-1]);
                num = 128'(dv < 0 ? -dv : dv) * 128'(f - pf);
                q   = num / 128'(nf - pf);
                return (dv < 0) ? VAL_W'(longint'(tbl_value[i-1]) - longint'(q))
                                : VAL_W'(longint'(tbl_value[i-1]) + longint'(q));
            end
        end
        return tbl_value[tbl_count-1];
    endfunction

    function automatic env_result_t apply_cmd(input cmd_t c);
        env_result_t r;
        int          pos;
        r.value  = '0;
        r.status = 1'b0;
        case (c.op)
            OP_CLEAR: tbl_count = 0;
            OP_INSERT:
            begin
                if (tbl_count >= MAX_POINTS)
                    r.status = 1'b1;
                else
                begin
                    pos = 0;
                    while (pos < tbl_count && tbl_frame[pos] <= c.frame)
                        pos++;
                    for (int j = tbl_count; j > pos; j--)
                    begin
                        tbl_frame[j] = tbl_frame[j-1];
                        tbl_value[j] = tbl_value[j-1];
                    end
                    tbl_frame[pos] = c.frame;
                    tbl_value[pos] = c.value;
                    tbl_count++;
                end
            end
            OP_QUERY: r.value = envelope_at(c.frame);
            default: ;
        endcase
        r.point_count = CNT_W'(tbl_count);
        return r;
    endfunction

    function automatic logic [FRAME_BITS-1:0] rand_frame();
        case ($urandom_range(0, 3))
            0: return FRAME_BITS'($urandom_range(0, 40));
            1: return FRAME_BITS'($urandom_range(0, 4000));
            2: return {16'($urandom), 32'($urandom)};
            default: return {FRAME_BITS{1'b1}} - FRAME_BITS'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 18'sh1FFFF;
            1: return 18'sh20000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic push_cmd(input op_t op, input logic [FRAME_BITS-1:0] f,
                            input logic signed [VAL_W-1:0] v);
        cmd_t c;
        c.op    = op;
        c.frame = f;
        c.value = v;
        pending_cmds = {pending_cmds, c};
    endtask

    // Wait until every queued command is sent and answered, then let the back end settle.
    task automatic drain();
        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DISCRETE)
            mdl_discrete = data[0];
        else
            mdl_default = data;
    endtask

    // Random traffic: mostly short envelopes built then queried, some noise.
    task automatic random_phase(input int n_items);
        int   sent;
        int   npts;
        logic [FRAME_BITS-1:0] base;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                push_cmd(OP_CLEAR, rand_frame(), rand_value());
                npts = $urandom_range(1, 8);
                base = ($urandom_range(0, 1) != 0) ? FRAME_BITS'($urandom_range(0, 500))
                                                   : rand_frame();
                for (int k = 0; k < npts; k++)
                    push_cmd(OP_INSERT, ($urandom_range(0, 3) == 0) ? base
                             : base + FRAME_BITS'($urandom_range(0, 300)), rand_value());
                for (int k = 0; k < 6; k++)
                    push_cmd(OP_QUERY, ($urandom_range(0, 4) == 0) ? rand_frame()
                             : base + FRAME_BITS'($urandom_range(0, 320)), rand_value());
                sent += npts + 7;
            end
            else
            begin
                push_cmd(op_t'($urandom_range(0, 3)), rand_frame(), rand_value());
                sent++;
            end
            while (pending_cmds.size() > 40)
                @(posedge clk);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Driver: one command per transaction, changed on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !in_taken)
            ;   // hold until accepted
        else if (pending_cmds.size() != 0 && !hold_sender &&
                 $urandom_range(0, 99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0, pending_cmds[0].value, pending_cmds[0].frame,
                         pending_cmds[0].op};
        end
        else
            s_tvalid <= 1'b0;
    end

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);

    // Acceptance: model updates on each input transaction; monitor checks outputs.
    always @(posedge clk)
    begin
        env_result_t want;
        cmd_t        c;
        in_taken = rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                c = pending_cmds.pop_front();
                expected_results = {expected_results, apply_cmd(c)};
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result %h", $realtime, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if ($signed(m_tdata[17:0]) != want.value)
                        report_mismatch("value_out", $signed(m_tdata[17:0]), want.value);
                    if (m_tdata[18] != want.status)
                        report_mismatch("status", m_tdata[18], want.status);
                    if (m_tdata[27:19] != want.point_count)
                        report_mismatch("point_count", m_tdata[27:19], want.point_count);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        error_count   = 0;
        quiet_cycles  = 0;
        hold_sender   = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 54;
        tbl_count     = 0;
        mdl_discrete  = 1'b0;
        mdl_default   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes, shared frames, no-op, both modes.
        push_cmd(OP_QUERY, '0, '0);
        push_cmd(OP_NOP, {FRAME_BITS{1'b1}}, 18'sh1FFFF);
        push_cmd(OP_INSERT, 48'd100, 18'sh20000);
        push_cmd(OP_INSERT, {FRAME_BITS{1'b1}}, 18'sh1FFFF);
        push_cmd(OP_INSERT, 48'd100, 18'sh00100);    // equal frame goes after
        push_cmd(OP_QUERY, 48'd0, '0);
        push_cmd(OP_QUERY, 48'd100, '0);
        push_cmd(OP_QUERY, 48'd101, '0);
        push_cmd(OP_QUERY, {FRAME_BITS{1'b1}} - 1, '0);
        push_cmd(OP_QUERY, {FRAME_BITS{1'b1}}, '0);
        push_cmd(OP_INSERT, 48'd200, -18'sd5);
        push_cmd(OP_QUERY, 48'd150, '0);
        push_cmd(OP_QUERY, 48'd300, '0);
        push_cmd(OP_CLEAR, '0, '0);
        push_cmd(OP_QUERY, 48'd7, '0);
        drain();
        write_reg(CFG_DISCRETE, 18'd1);
        write_reg(CFG_DEFAULT, 18'h20000);
        push_cmd(OP_QUERY, 48'd7, '0);
        push_cmd(OP_INSERT, 48'd10, 18'sd1000);
        push_cmd(OP_INSERT, 48'd20, -18'sd1000);
        push_cmd(OP_QUERY, 48'd15, '0);
        push_cmd(OP_QUERY, 48'd20, '0);
        push_cmd(OP_QUERY, 48'd25, '0);
        drain();
        write_reg(CFG_DEFAULT, 18'h1FFFF);
        write_reg(CFG_DISCRETE, 18'd0);

        // Fill to capacity, then overflow inserts (all appended: fast).
        hold_sender = 1'b0;
        push_cmd(OP_CLEAR, '0, '0);
        for (int k = 0; k < MAX_POINTS + 3; k++)
            push_cmd(OP_INSERT, FRAME_BITS'(k * 8), rand_value());
        for (int k = 0; k < 4; k++)
            push_cmd(OP_QUERY, FRAME_BITS'($urandom_range(0, 2100)), '0);
        push_cmd(OP_QUERY, FRAME_BITS'(64), '0);
        push_cmd(OP_CLEAR, '0, '0);

        random_phase(350);
        // Sender pause until every result has come back.
        hold_sender = 1'b1;
        while (expected_results.size() != 0)
            @(posedge clk);
        hold_sender = 1'b0;
        drain();
        write_reg(CFG_DISCRETE, 18'd1);
        write_reg(CFG_DEFAULT, VAL_W'($urandom));
        send_idle_pct = 54;
        recv_idle_pct = 25;
        random_phase(400);
        drain();
        write_reg(CFG_DISCRETE, 18'd0);
        write_reg(CFG_DEFAULT, 18'h00000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(400);
        drain();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/bet_pkg.sv
rtl/bet_front.sv
rtl/bet_back.sv
rtl/breakpoint_envelope_table.sv
sim/breakpoint_envelope_table_tb.sv
